// ===== hdl/pixel_color_adjust_top_defines.svh =====
`ifndef PIXEL_COLOR_ADJUST_TOP_DEFINES_SVH
`define PIXEL_COLOR_ADJUST_TOP_DEFINES_SVH
// assertion helpers, sampled on clk and quiet while rst_n is low
`define PCADJ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PCADJ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== hdl/pcadj_pkg.sv =====
`timescale 1ns / 1ps
package pcadj_pkg;

    localparam int COEF_FRAC_BITS_DEF = 12;
    localparam int Q16_FRAC           = 16;

    localparam logic signed [31:0] HALF_Q16 = 32'sd32768;
    localparam logic signed [31:0] ONE_Q16  = 32'sd65536;
    localparam logic signed [31:0] MAX_S32  = 32'sh7fffffff;

    // rec.709 luma weights, q.16
    localparam logic signed [16:0] LUMA_R = 17'sd13933;
    localparam logic signed [16:0] LUMA_G = 17'sd46871;
    localparam logic signed [16:0] LUMA_B = 17'sd4732;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // chroma divider: quotient bits and bits resolved per stage
    localparam int DIV_Q_BITS         = 32;
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = DIV_Q_BITS / DIV_BITS_PER_STAGE;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_RED,
        REG_GAIN_GREEN,
        REG_GAIN_BLUE,
        REG_CONTRAST,
        REG_SHADOW,
        REG_HIGHLIGHT,
        REG_SATURATION,
        REG_VIBRANCE
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } pix_out_t;

    // one divider stage: partial remainder, dividend bits shifting into quotient
    typedef struct packed {
        logic [30:0]           rem;
        logic [DIV_Q_BITS-1:0] word;
        logic [30:0]           divisor;
    } div_req_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] a);
        if (a > 64'sd2147483647) begin
            return MAX_S32;
        end
        if (a < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return a[31:0];
    endfunction

    // floor(a / 2^s + 1/2)
    function automatic logic signed [63:0] rshift(input logic signed [63:0] a, input int s);
        logic signed [63:0] half;
        half = 64'sd1 <<< (s - 1);
        return (a + half) >>> s;
    endfunction

    function automatic logic signed [31:0] mulq(input logic signed [63:0] p, input int s);
        return sat32(rshift(p, s));
    endfunction

endpackage

// ===== hdl/pcadj_div.sv =====
`timescale 1ns / 1ps
module pcadj_div
    import pcadj_pkg::*;
(
    input  logic                  clk,
    input  logic                  en,
    input  div_req_t              req,
    output logic [DIV_Q_BITS-1:0] quot
);

    div_req_t stage_reg  [DIV_STAGES];
    div_req_t stage_next [DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++) begin : g_stage
            div_req_t src;
            if (k == 0) begin : g_first
                assign src = req;
            end
            else begin : g_rest
                assign src = stage_reg[k-1];
            end

            always_comb begin
                div_req_t   cur;
                logic [31:0] trial;
                logic       qbit;
                cur = src;
                for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
                    trial = {cur.rem, cur.word[DIV_Q_BITS-1]};
                    qbit  = (trial >= {1'b0, cur.divisor});
                    if (qbit) begin
                        trial = trial - {1'b0, cur.divisor};
                    end
                    cur.rem  = trial[30:0];
                    cur.word = {cur.word[DIV_Q_BITS-2:0], qbit};
                end
                stage_next[k] = cur;
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign quot = stage_reg[DIV_STAGES-1].word;

endmodule

// ===== hdl/pixel_color_adjust_top.sv =====
`timescale 1ns / 1ps
// pixel color adjuster: takes one 8-bit rgb pixel per clock and returns one adjusted
// pixel per clock while not stalled, in order, through 14 arithmetic stages, a 16-stage
// chroma divider resolving two quotient bits per stage, and 4 output stages.
// the whole pipeline advances together; it stalls only when a finished pixel sits in
// the output register and result_ready is low, and then pixel_ready drops the same
// cycle. registers are written through the cfg channel, which is always ready; write
// them only while no pixel is in flight.
`include "pixel_color_adjust_top_defines.svh"
module pixel_color_adjust_top
    import pcadj_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // pixel requests in
    input  logic                  pixel_valid,
    output logic                  pixel_ready,
    input  pix_in_t               pixel,
    // adjusted pixels out
    output logic                  result_valid,
    input  logic                  result_ready,
    output pix_out_t              result,
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PRE_STAGES  = 14;
    localparam int POST_STAGES = 4;
    localparam int N_STAGES    = PRE_STAGES + DIV_STAGES + POST_STAGES;
    localparam int VMIX_SHIFT  = Q16_FRAC - COEF_FRAC_BITS;

    // values riding alongside the divider
    typedef struct packed {
        logic signed [31:0] cr;
        logic signed [31:0] cg;
        logic signed [31:0] cb;
        logic signed [31:0] gray;
        logic               pos;
        logic               sat;
    } side_t;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [15:0] gain_red_reg, gain_green_reg, gain_blue_reg;
    logic [15:0] contrast_reg, saturation_reg, vibrance_reg;
    logic [31:0] shadow_reg, highlight_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_red_reg   <= 16'd4096;
            gain_green_reg <= 16'd4096;
            gain_blue_reg  <= 16'd4096;
            contrast_reg   <= 16'd4096;
            shadow_reg     <= '0;
            highlight_reg  <= '0;
            saturation_reg <= 16'd4096;
            vibrance_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GAIN_RED:   gain_red_reg   <= cfg_data[15:0];
                REG_GAIN_GREEN: gain_green_reg <= cfg_data[15:0];
                REG_GAIN_BLUE:  gain_blue_reg  <= cfg_data[15:0];
                REG_CONTRAST:   contrast_reg   <= cfg_data[15:0];
                REG_SHADOW:     shadow_reg     <= cfg_data;
                REG_HIGHLIGHT:  highlight_reg  <= cfg_data;
                REG_SATURATION: saturation_reg <= cfg_data[15:0];
                REG_VIBRANCE:   vibrance_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // signed views of the coefficient fields; the gains stay unsigned
    logic signed [15:0] cf, w_sh, w_bl, w_hi, w_wh, sat_g, vib_w;
    logic        [15:0] gain [3];

    assign cf    = contrast_reg;
    assign w_sh  = shadow_reg[15:0];
    assign w_bl  = shadow_reg[31:16];
    assign w_hi  = highlight_reg[15:0];
    assign w_wh  = highlight_reg[31:16];
    assign sat_g = saturation_reg;
    assign vib_w = vibrance_reg;
    assign gain[0] = gain_red_reg;
    assign gain[1] = gain_green_reg;
    assign gain[2] = gain_blue_reg;

    // ---------------------------------------------------------------
    // pipeline control: every stage moves when the output register is free
    // ---------------------------------------------------------------
    logic                vld_reg [N_STAGES];
    logic [N_STAGES-1:0] vld_vec;
    logic                pipe_en;

    assign pipe_en      = !vld_reg[N_STAGES-1] || result_ready;
    assign pixel_ready  = pipe_en;
    assign result_valid = vld_reg[N_STAGES-1];

    always_comb begin
        for (int i = 0; i < N_STAGES; i++) begin
            vld_vec[i] = vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N_STAGES; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (pipe_en)
        begin
            vld_reg[0] <= pixel_valid;
            for (int i = 1; i < N_STAGES; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // stage registers
    // ---------------------------------------------------------------
    // gain and contrast
    logic        [32:0] s1_prod_reg [3], s1_prod_next [3];
    logic signed [47:0] s2_prod_reg [3], s2_prod_next [3];
    logic signed [31:0] s3_c_reg    [3], s3_c_next    [3];
    // first luma
    logic signed [48:0] s4_lp_reg   [3], s4_lp_next   [3];
    logic signed [31:0] s4_c_reg    [3];
    logic signed [31:0] s5_lum_reg, s5_lum_next, s5_inv_reg, s5_inv_next;
    logic signed [31:0] s5_c_reg    [3];
    // tone curve
    logic signed [63:0] s6_pll_reg, s6_pll_next, s6_pii_reg, s6_pii_next;
    logic signed [47:0] s6_psh_reg, s6_psh_next;
    logic signed [31:0] s6_lum_reg, s6_inv_reg;
    logic signed [31:0] s6_c_reg    [3];
    logic signed [31:0] s7_h2_reg, s7_h2_next, s7_s2_reg, s7_s2_next;
    logic signed [31:0] s7_ash_reg, s7_ash_next, s7_lum_reg, s7_inv_reg;
    logic signed [31:0] s7_c_reg    [3];
    logic signed [63:0] s8_ps3_reg, s8_ps3_next, s8_ph3_reg, s8_ph3_next;
    logic signed [47:0] s8_phi_reg, s8_phi_next;
    logic signed [31:0] s8_ash_reg;
    logic signed [31:0] s8_c_reg    [3];
    logic signed [31:0] s9_s3_reg, s9_s3_next, s9_h3_reg, s9_h3_next;
    logic signed [31:0] s9_ahi_reg, s9_ahi_next, s9_ash_reg;
    logic signed [31:0] s9_c_reg    [3];
    logic signed [47:0] s10_pbl_reg, s10_pbl_next, s10_pwh_reg, s10_pwh_next;
    logic signed [31:0] s10_ahi_reg, s10_ash_reg;
    logic signed [31:0] s10_c_reg   [3];
    logic signed [31:0] s11_lift_reg, s11_lift_next, s11_hgain_reg, s11_hgain_next;
    logic signed [31:0] s11_c_reg   [3];
    // lifted pixel, max/min and second luma
    logic signed [31:0] s12_c_reg   [3], s12_c_next   [3];
    logic signed [31:0] s13_mx_reg, s13_mx_next, s13_mn_reg, s13_mn_next;
    logic signed [48:0] s13_lp_reg  [3], s13_lp_next  [3];
    logic signed [31:0] s13_c_reg   [3];
    // divider launch
    div_req_t           s14_req_reg, s14_req_next;
    side_t              s14_side_reg, s14_side_next;
    side_t              side_reg [DIV_STAGES];
    logic [DIV_Q_BITS-1:0] quot;
    // saturation mix and output
    logic signed [49:0] p1_pvib_reg, p1_pvib_next;
    side_t              p1_side_reg;
    logic signed [31:0] p2_vmix_reg, p2_vmix_next, p2_gray_reg;
    logic signed [31:0] p2_diff_reg [3], p2_diff_next [3];
    logic signed [63:0] p3_prod_reg [3], p3_prod_next [3];
    logic signed [31:0] p3_gray_reg;
    pix_out_t           result_reg, result_next;

    // ---------------------------------------------------------------
    // stage logic
    // ---------------------------------------------------------------
    always_comb begin
        logic        [7:0]  x   [3];
        logic        [16:0] v17;
        logic signed [31:0] m, d, t, b_bl, b_wh, dl, mx, mn, satp, v;
        logic signed [33:0] one_minus;
        logic        [31:0] dd;
        logic        [23:0] ro;
        logic        [7:0]  och [3];
        logic signed [31:0] sc  [3];

        x[0] = pixel.red_in;
        x[1] = pixel.green_in;
        x[2] = pixel.blue_in;

        for (int i = 0; i < 3; i++) begin
            // x * 65536 / 255 rounded: x * 257 plus one for the upper half
            v17             = 17'({x[i], x[i]}) + 17'(x[i][7]);
            s1_prod_next[i] = 33'(v17) * 33'(gain[i]);

            m               = mulq(64'(s1_prod_reg[i]), COEF_FRAC_BITS);
            d               = sat32(64'(m) - 64'(HALF_Q16));
            s2_prod_next[i] = d * cf;

            t               = mulq(64'(s2_prod_reg[i]), COEF_FRAC_BITS);
            s3_c_next[i]    = sat32(64'(t) + 64'(HALF_Q16));
        end

        s4_lp_next[0] = s3_c_reg[0] * LUMA_R;
        s4_lp_next[1] = s3_c_reg[1] * LUMA_G;
        s4_lp_next[2] = s3_c_reg[2] * LUMA_B;

        // luma clamped at zero, and its complement
        s5_lum_next = mulq(64'(s4_lp_reg[0]) + 64'(s4_lp_reg[1]) + 64'(s4_lp_reg[2]),
                           Q16_FRAC);
        if (s5_lum_next < 0) begin
            s5_lum_next = '0;
        end
        s5_inv_next = sat32(64'(ONE_Q16) - 64'(s5_lum_next));

        s6_pll_next = s5_lum_reg * s5_lum_reg;
        s6_pii_next = s5_inv_reg * s5_inv_reg;
        s6_psh_next = w_sh * s5_inv_reg;

        s7_h2_next  = mulq(s6_pll_reg, Q16_FRAC);
        s7_s2_next  = mulq(s6_pii_reg, Q16_FRAC);
        s7_ash_next = mulq(64'(s6_psh_reg), COEF_FRAC_BITS);

        s8_ps3_next = s7_s2_reg * s7_inv_reg;
        s8_ph3_next = s7_h2_reg * s7_lum_reg;
        s8_phi_next = w_hi * s7_h2_reg;

        s9_s3_next  = mulq(s8_ps3_reg, Q16_FRAC);
        s9_h3_next  = mulq(s8_ph3_reg, Q16_FRAC);
        s9_ahi_next = mulq(64'(s8_phi_reg), COEF_FRAC_BITS);

        s10_pbl_next = w_bl * s9_s3_reg;
        s10_pwh_next = w_wh * s9_h3_reg;

        b_bl           = mulq(64'(s10_pbl_reg), COEF_FRAC_BITS);
        b_wh           = mulq(64'(s10_pwh_reg), COEF_FRAC_BITS);
        s11_lift_next  = sat32(64'(s10_ash_reg) + 64'(b_bl));
        s11_hgain_next = sat32(64'(s10_ahi_reg) + 64'(b_wh));

        // same offset on all three channels
        dl = sat32(64'(s11_lift_reg) + 64'(s11_hgain_reg));
        for (int i = 0; i < 3; i++) begin
            s12_c_next[i] = sat32(64'(s11_c_reg[i]) + 64'(dl));
        end

        mx = s12_c_reg[0];
        mn = s12_c_reg[0];
        for (int i = 1; i < 3; i++) begin
            if (s12_c_reg[i] > mx) begin
                mx = s12_c_reg[i];
            end
            if (s12_c_reg[i] < mn) begin
                mn = s12_c_reg[i];
            end
        end
        s13_mx_next   = mx;
        s13_mn_next   = mn;
        s13_lp_next[0] = s12_c_reg[0] * LUMA_R;
        s13_lp_next[1] = s12_c_reg[1] * LUMA_G;
        s13_lp_next[2] = s12_c_reg[2] * LUMA_B;

        // chroma = (max - min) * 65536 / max; quotient at or past 2^31 saturates
        dd = s13_mx_reg - s13_mn_reg;
        s14_side_next.cr   = s13_c_reg[0];
        s14_side_next.cg   = s13_c_reg[1];
        s14_side_next.cb   = s13_c_reg[2];
        s14_side_next.gray = mulq(64'(s13_lp_reg[0]) + 64'(s13_lp_reg[1])
                                  + 64'(s13_lp_reg[2]), Q16_FRAC);
        s14_side_next.pos  = (s13_mx_reg > 0);
        s14_side_next.sat  = ({15'd0, dd} >= {s13_mx_reg, 15'd0});
        s14_req_next.rem     = {15'd0, dd[31:16]};
        s14_req_next.word    = {dd[15:0], 16'd0};
        s14_req_next.divisor = s13_mx_reg[30:0];

        // saturation factor
        if (!side_reg[DIV_STAGES-1].pos) begin
            satp = '0;
        end
        else if (side_reg[DIV_STAGES-1].sat) begin
            satp = MAX_S32;
        end
        else begin
            satp = quot;
        end
        one_minus    = 34'sd65536 - 34'(satp);
        p1_pvib_next = vib_w * one_minus;

        p2_vmix_next = sat32((64'(sat_g) <<< VMIX_SHIFT)
                             + rshift(64'(p1_pvib_reg), COEF_FRAC_BITS));
        sc[0] = p1_side_reg.cr;
        sc[1] = p1_side_reg.cg;
        sc[2] = p1_side_reg.cb;
        for (int i = 0; i < 3; i++) begin
            p2_diff_next[i] = sat32(64'(sc[i]) - 64'(p1_side_reg.gray));
            p3_prod_next[i] = p2_diff_reg[i] * p2_vmix_reg;
        end

        // mix about grey, clamp to [0,1], round to 8 bits
        for (int i = 0; i < 3; i++) begin
            v = sat32(64'(p3_gray_reg) + 64'(mulq(p3_prod_reg[i], Q16_FRAC)));
            if (v < 0) begin
                v = '0;
            end
            if (v > ONE_Q16) begin
                v = ONE_Q16;
            end
            ro     = 24'(v[16:0]) * 24'd255 + 24'd32768;
            och[i] = ro[23:16];
        end
        result_next.red_out   = och[0];
        result_next.green_out = och[1];
        result_next.blue_out  = och[2];
    end

    pcadj_div u_div (
        .clk  (clk),
        .en   (pipe_en),
        .req  (s14_req_reg),
        .quot (quot)
    );

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s1_prod_reg   <= s1_prod_next;
            s2_prod_reg   <= s2_prod_next;
            s3_c_reg      <= s3_c_next;
            s4_lp_reg     <= s4_lp_next;
            s4_c_reg      <= s3_c_reg;
            s5_lum_reg    <= s5_lum_next;
            s5_inv_reg    <= s5_inv_next;
            s5_c_reg      <= s4_c_reg;
            s6_pll_reg    <= s6_pll_next;
            s6_pii_reg    <= s6_pii_next;
            s6_psh_reg    <= s6_psh_next;
            s6_lum_reg    <= s5_lum_reg;
            s6_inv_reg    <= s5_inv_reg;
            s6_c_reg      <= s5_c_reg;
            s7_h2_reg     <= s7_h2_next;
            s7_s2_reg     <= s7_s2_next;
            s7_ash_reg    <= s7_ash_next;
            s7_lum_reg    <= s6_lum_reg;
            s7_inv_reg    <= s6_inv_reg;
            s7_c_reg      <= s6_c_reg;
            s8_ps3_reg    <= s8_ps3_next;
            s8_ph3_reg    <= s8_ph3_next;
            s8_phi_reg    <= s8_phi_next;
            s8_ash_reg    <= s7_ash_reg;
            s8_c_reg      <= s7_c_reg;
            s9_s3_reg     <= s9_s3_next;
            s9_h3_reg     <= s9_h3_next;
            s9_ahi_reg    <= s9_ahi_next;
            s9_ash_reg    <= s8_ash_reg;
            s9_c_reg      <= s8_c_reg;
            s10_pbl_reg   <= s10_pbl_next;
            s10_pwh_reg   <= s10_pwh_next;
            s10_ahi_reg   <= s9_ahi_reg;
            s10_ash_reg   <= s9_ash_reg;
            s10_c_reg     <= s9_c_reg;
            s11_lift_reg  <= s11_lift_next;
            s11_hgain_reg <= s11_hgain_next;
            s11_c_reg     <= s10_c_reg;
            s12_c_reg     <= s12_c_next;
            s13_mx_reg    <= s13_mx_next;
            s13_mn_reg    <= s13_mn_next;
            s13_lp_reg    <= s13_lp_next;
            s13_c_reg     <= s12_c_reg;
            s14_req_reg   <= s14_req_next;
            s14_side_reg  <= s14_side_next;
            side_reg[0]   <= s14_side_reg;
            for (int i = 1; i < DIV_STAGES; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
            p1_pvib_reg   <= p1_pvib_next;
            p1_side_reg   <= side_reg[DIV_STAGES-1];
            p2_vmix_reg   <= p2_vmix_next;
            p2_diff_reg   <= p2_diff_next;
            p2_gray_reg   <= p1_side_reg.gray;
            p3_prod_reg   <= p3_prod_next;
            p3_gray_reg   <= p2_gray_reg;
            result_reg    <= result_next;
        end
    end

    assign result = result_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    `PCADJ_ASSERT_NEXT(a_accept_enters, pixel_valid && pixel_ready, vld_reg[0], "accepted request lost at pipeline entry")
    `PCADJ_ASSERT_NEXT(a_stall_holds, !pipe_en, $stable(vld_vec), "pipeline occupancy moved during a stall")
    `PCADJ_ASSERT_SAME(a_empty_out_ready, !result_valid, pixel_ready, "input blocked with an empty output register")
    `PCADJ_ASSERT_NEXT(a_no_phantom, pipe_en && !pixel_valid, !vld_reg[0], "bubble turned into a request")

endmodule

// ===== sim/tb_pixel_color_adjust_top.sv =====
`timescale 1ns / 1ps
module tb_pixel_color_adjust_top;
    import pcadj_pkg::*;

    localparam int CFB        = COEF_FRAC_BITS_DEF;
    localparam int LATENCY    = 34;
    localparam int N_RANDOM   = 650;
    localparam int CYCLE_CAP  = 400000;

    logic            clk;
    logic            rst_n;
    logic            pixel_valid;
    logic            pixel_ready;
    pix_in_t         pixel;
    logic            result_valid;
    logic            result_ready;
    pix_out_t        result;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [2:0]      cfg_index;
    logic [31:0]     cfg_data;

    pixel_color_adjust_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // local copy of the register file, indexed by cfg_reg_t
    logic [31:0] shadow_regs [8];

    pix_out_t    adjusted_queue[$];
    int          n_errors;
    int          n_checked;
    int          n_sent;
    longint      cycle_count;
    bit          hold_off;    // forces the receiver into a long stall

    // directed table: pixel, config preset, expected result when it is obvious
    typedef struct {
        pix_in_t  px;
        int       preset;
        bit       known;
        pix_out_t want;
    } dir_row_t;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------- prediction ----------------

    function automatic longint clip32(longint a);
        if (a > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (a < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return a;
    endfunction

    // floor(a / 2^s + 1/2)
    function automatic longint round_half_up(longint a, int s);
        longint t;
        if (s == 0)
        begin
            return a;
        end
        t = a + (64'sd1 <<< (s - 1));
        return t >>> s;
    endfunction

    function automatic longint fxmul(longint a, longint b, int s);
        return clip32(round_half_up(a * b, s));
    endfunction

    function automatic longint luma_q16(longint r, longint g, longint b);
        return clip32(round_half_up(r * 13933 + g * 46871 + b * 4732, 16));
    endfunction

    function automatic longint as_s16(logic [15:0] v);
        return longint'($signed(v));
    endfunction

    function automatic pix_out_t adjust_pixel(pix_in_t px);
        longint   ch [3];
        longint   gn [3];
        logic [7:0] src [3];
        longint   cf, w_sh, w_bl, w_hi, w_wh, sat_g, vib_w;
        longint   lum, inv, h2, s2, lift, hgain, delta, mx, mn, chroma, gray, mix, v;
        logic [7:0] dst [3];
        pix_out_t o;
        src[0] = px.red_in;
        src[1] = px.green_in;
        src[2] = px.blue_in;
        gn[0]  = longint'(shadow_regs[REG_GAIN_RED][15:0]);
        gn[1]  = longint'(shadow_regs[REG_GAIN_GREEN][15:0]);
        gn[2]  = longint'(shadow_regs[REG_GAIN_BLUE][15:0]);
        cf     = as_s16(shadow_regs[REG_CONTRAST][15:0]);
        w_sh   = as_s16(shadow_regs[REG_SHADOW][15:0]);
        w_bl   = as_s16(shadow_regs[REG_SHADOW][31:16]);
        w_hi   = as_s16(shadow_regs[REG_HIGHLIGHT][15:0]);
        w_wh   = as_s16(shadow_regs[REG_HIGHLIGHT][31:16]);
        sat_g  = as_s16(shadow_regs[REG_SATURATION][15:0]);
        vib_w  = as_s16(shadow_regs[REG_VIBRANCE][15:0]);

        for (int i = 0; i < 3; i++)
        begin
            v     = (longint'(src[i]) * 65536 + 127) / 255;
            v     = fxmul(v, gn[i], CFB);
            v     = fxmul(clip32(v - 32768), cf, CFB);
            ch[i] = clip32(v + 32768);
        end

        lum = luma_q16(ch[0], ch[1], ch[2]);
        if (lum < 0)
        begin
            lum = 0;
        end
        inv   = clip32(65536 - lum);
        h2    = fxmul(lum, lum, 16);
        s2    = fxmul(inv, inv, 16);
        lift  = clip32(fxmul(w_sh, inv, CFB) + fxmul(w_bl, fxmul(s2, inv, 16), CFB));
        hgain = clip32(fxmul(w_hi, h2, CFB) + fxmul(w_wh, fxmul(h2, lum, 16), CFB));
        delta = clip32(lift + hgain);
        for (int i = 0; i < 3; i++)
        begin
            ch[i] = clip32(ch[i] + delta);
        end

        mx = ch[0];
        mn = ch[0];
        for (int i = 1; i < 3; i++)
        begin
            if (ch[i] > mx) mx = ch[i];
            if (ch[i] < mn) mn = ch[i];
        end
        // dark pixel: chroma forced to zero
        chroma = (mx > 0) ? clip32(((mx - mn) * 65536) / mx) : 0;
        gray   = luma_q16(ch[0], ch[1], ch[2]);
        mix    = clip32(sat_g * (64'sd1 <<< (16 - CFB))
                        + round_half_up(vib_w * (65536 - chroma), CFB));

        for (int i = 0; i < 3; i++)
        begin
            v = clip32(gray + fxmul(clip32(ch[i] - gray), mix, 16));
            if (v < 0) v = 0;
            if (v > 65536) v = 65536;
            dst[i] = 8'((v * 255 + 32768) >>> 16);
        end
        o.red_out   = dst[0];
        o.green_out = dst[1];
        o.blue_out  = dst[2];
        return o;
    endfunction

    // ---------------- drivers ----------------

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_SHADOW, REG_HIGHLIGHT: shadow_regs[idx] = data;
            default:                   shadow_regs[idx] = {16'h0, data[15:0]};
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // the expectation is queued when the request is accepted; valid stays up until
    // the next falling edge so that a request with no gap follows back to back
    task automatic send_pixel(pix_in_t px, int gap, bit known, pix_out_t want);
        for (int g = 0; g < gap; g++)
        begin
            @(negedge clk);
            pixel_valid <= 1'b0;
        end
        @(negedge clk);
        pixel_valid <= 1'b1;
        pixel       <= px;
        @(posedge clk);
        while (!pixel_ready)
        begin
            @(posedge clk);
        end
        adjusted_queue.push_back(known ? want : adjust_pixel(px));
        n_sent++;
    endtask

    // drop valid, drain all expected results, then wait out the pipeline
    task automatic wait_idle();
        @(negedge clk);
        pixel_valid <= 1'b0;
        while (adjusted_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic load_preset(int p);
        case (p)
            0:
            begin
                write_reg(REG_GAIN_RED, 32'd4096);
                write_reg(REG_GAIN_GREEN, 32'd4096);
                write_reg(REG_GAIN_BLUE, 32'd4096);
                write_reg(REG_CONTRAST, 32'd4096);
                write_reg(REG_SHADOW, 32'd0);
                write_reg(REG_HIGHLIGHT, 32'd0);
                write_reg(REG_SATURATION, 32'd4096);
                write_reg(REG_VIBRANCE, 32'd0);
            end
            1:
            begin
                // extremes: max red and green gains, zero blue gain, most negative contrast, weights at both ends
                write_reg(REG_GAIN_RED, 32'hffff);
                write_reg(REG_GAIN_GREEN, 32'hffff);
                write_reg(REG_GAIN_BLUE, 32'h0000);
                write_reg(REG_CONTRAST, 32'h8000);
                write_reg(REG_SHADOW, 32'h8000_7fff);
                write_reg(REG_HIGHLIGHT, 32'h7fff_8000);
                write_reg(REG_SATURATION, 32'h7fff);
                write_reg(REG_VIBRANCE, 32'h8000);
            end
            2:
            begin
                // zero saturation gain with full vibrance, and boost shadows
                write_reg(REG_GAIN_RED, 32'd5000);
                write_reg(REG_GAIN_GREEN, 32'd3000);
                write_reg(REG_GAIN_BLUE, 32'd4500);
                write_reg(REG_CONTRAST, 32'd6000);
                write_reg(REG_SHADOW, 32'h0800_0400);
                write_reg(REG_HIGHLIGHT, 32'hfc00_fe00);
                write_reg(REG_SATURATION, 32'd0);
                write_reg(REG_VIBRANCE, 32'h7fff);
            end
            default:
            begin
                write_reg(REG_GAIN_RED, $urandom_range(0, 65535));
                write_reg(REG_GAIN_GREEN, $urandom_range(0, 65535));
                write_reg(REG_GAIN_BLUE, $urandom_range(0, 65535));
                write_reg(REG_CONTRAST, $urandom_range(0, 65535));
                write_reg(REG_SHADOW, $urandom());
                write_reg(REG_HIGHLIGHT, $urandom());
                write_reg(REG_SATURATION, $urandom_range(0, 65535));
                write_reg(REG_VIBRANCE, $urandom_range(0, 65535));
            end
        endcase
    endtask

    // ---------------- checker ----------------

    always @(posedge clk)
    begin
        pix_out_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (adjusted_queue.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                n_errors++;
            end
            else
            begin
                want = adjusted_queue.pop_front();
                n_checked++;
                if (result.red_out !== want.red_out)
                begin
                    $display("%0t: red expected %0d actual %0d", $time,
                             want.red_out, result.red_out);
                    n_errors++;
                end
                if (result.green_out !== want.green_out)
                begin
                    $display("%0t: green expected %0d actual %0d", $time,
                             want.green_out, result.green_out);
                    n_errors++;
                end
                if (result.blue_out !== want.blue_out)
                begin
                    $display("%0t: blue expected %0d actual %0d", $time,
                             want.blue_out, result.blue_out);
                    n_errors++;
                end
            end
        end
    end

    // receiver: random stalls, plus a long forced stall while hold_off is set
    initial
    begin
        int gap;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                result_ready <= 1'b0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                // ready drops even when pick_gap returns zero
                gap = pick_gap() + 1;
                result_ready <= 1'b0;
                repeat (gap) @(negedge clk);
                result_ready <= 1'b1;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    // ---------------- stimulus ----------------

    dir_row_t directed [$];

    function automatic dir_row_t row(logic [7:0] r, logic [7:0] g, logic [7:0] b, int p,
                                     bit k, logic [7:0] er, logic [7:0] eg, logic [7:0] eb);
        dir_row_t d;
        d.px     = '{r, g, b};
        d.preset = p;
        d.known  = k;
        d.want   = '{er, eg, eb};
        return d;
    endfunction

    initial
    begin
        int cur_preset;
        pix_in_t px;
        int burst;
        rst_n       = 1'b0;
        pixel_valid = 1'b0;
        pixel       = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        hold_off    = 1'b0;
        n_errors    = 0;
        n_checked   = 0;
        n_sent      = 0;
        cycle_count = 0;
        // values after reset
        shadow_regs[REG_GAIN_RED]   = 4096;
        shadow_regs[REG_GAIN_GREEN] = 4096;
        shadow_regs[REG_GAIN_BLUE]  = 4096;
        shadow_regs[REG_CONTRAST]   = 4096;
        shadow_regs[REG_SHADOW]     = 0;
        shadow_regs[REG_HIGHLIGHT]  = 0;
        shadow_regs[REG_SATURATION] = 4096;
        shadow_regs[REG_VIBRANCE]   = 0;

        // identity settings pass black, white and grey through untouched
        directed.push_back(row(8'd0, 8'd0, 8'd0, -1, 1, 8'd0, 8'd0, 8'd0));
        directed.push_back(row(8'd255, 8'd255, 8'd255, -1, 1, 8'd255, 8'd255, 8'd255));
        directed.push_back(row(8'd128, 8'd128, 8'd128, -1, 1, 8'd128, 8'd128, 8'd128));
        directed.push_back(row(8'd255, 8'd0, 8'd0, -1, 0, '0, '0, '0));
        directed.push_back(row(8'd0, 8'd255, 8'd0, -1, 0, '0, '0, '0));
        directed.push_back(row(8'd0, 8'd0, 8'd255, -1, 0, '0, '0, '0));
        directed.push_back(row(8'haa, 8'h55, 8'hff, -1, 0, '0, '0, '0));
        // saturated extremes: clamping, negative channels, chroma above one
        directed.push_back(row(8'd0, 8'd0, 8'd0, 1, 0, '0, '0, '0));
        directed.push_back(row(8'd255, 8'd255, 8'd255, 1, 0, '0, '0, '0));
        directed.push_back(row(8'd255, 8'd0, 8'd128, 1, 0, '0, '0, '0));
        directed.push_back(row(8'd1, 8'd254, 8'd7, 1, 0, '0, '0, '0));
        directed.push_back(row(8'h55, 8'haa, 8'h00, 1, 0, '0, '0, '0));
        // zero saturation gain with full vibrance; shadow lift on dark pixels
        directed.push_back(row(8'd0, 8'd0, 8'd0, 2, 0, '0, '0, '0));
        directed.push_back(row(8'd3, 8'd1, 8'd2, 2, 0, '0, '0, '0));
        directed.push_back(row(8'd200, 8'd30, 8'd90, 2, 0, '0, '0, '0));
        directed.push_back(row(8'd255, 8'd255, 8'd0, 2, 0, '0, '0, '0));
        directed.push_back(row(8'd128, 8'd64, 8'd32, 2, 0, '0, '0, '0));
        // back to identity
        directed.push_back(row(8'd17, 8'd99, 8'd240, 0, 0, '0, '0, '0));
        directed.push_back(row(8'd0, 8'd0, 8'd0, 0, 1, 8'd0, 8'd0, 8'd0));

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        cur_preset = -1;
        foreach (directed[i])
        begin
            if (directed[i].preset >= 0 && directed[i].preset != cur_preset)
            begin
                wait_idle();
                load_preset(directed[i].preset);
                cur_preset = directed[i].preset;
            end
            send_pixel(directed[i].px, pick_gap(), directed[i].known, directed[i].want);
        end

        // random phases, each under its own register setting
        for (int ph = 0; ph < 8; ph++)
        begin
            wait_idle();
            load_preset((ph == 0) ? 0 : (ph == 3) ? 1 : 3);
            // one phase fills the pipeline with the receiver held off
            if (ph == 2)
            begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (120) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int k = 0; k < N_RANDOM / 8; k++)
            begin
                px.red_in   = $urandom_range(0, 255);
                px.green_in = $urandom_range(0, 255);
                px.blue_in  = $urandom_range(0, 255);
                // back-to-back with no gap in phase 2, elsewhere at least half the time
                burst = (ph == 2 || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
                send_pixel(px, burst, 1'b0, '0);
            end
        end

        wait_idle();
        $display("checked %0d of %0d pixels over directed extremes and 8 random phases",
                 n_checked, n_sent);
        if (n_errors == 0 && adjusted_queue.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("%0d field errors, %0d results missing", n_errors,
                     adjusted_queue.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
